### rtl/qspm_pkg.sv
`default_nettype none

package qspm_pkg;

    localparam int QUAT_W  = 16;
    localparam int SCALE_W = 16;
    localparam int POS_W   = 32;
    localparam int PROD_W  = 2 * QUAT_W;
    localparam int ROT_W   = PROD_W + 2;
    localparam int WIDE_W  = ROT_W + SCALE_W;
    localparam int ENTRY_W = 32;
    localparam int DROP_W  = 22;
    localparam int ROT_N   = 9;
    localparam int AXES    = 3;

    localparam int IN_DATA_W  = 4 * QUAT_W + AXES * SCALE_W + AXES * POS_W;
    localparam int OUT_DATA_W = (ROT_N + AXES) * ENTRY_W;

    localparam logic signed [ROT_W-1:0]  ONE_Q30    = ROT_W'(64'sd1 <<< 30);
    localparam logic signed [WIDE_W-1:0] ROUND_HALF = WIDE_W'(64'sd1 <<< (DROP_W - 1));

    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ROT_W-1:0]   rot_t;
    typedef logic signed [SCALE_W-1:0] scale_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;
    typedef logic signed [ENTRY_W-1:0] entry_t;

    // round half up, drop fraction bits, clamp to the entry range
    function automatic entry_t round_sat(input wide_t v);
        wide_t                            sum;
        logic signed [WIDE_W-DROP_W-1:0]  shifted;
        entry_t                           res;
        sum     = v + ROUND_HALF;
        shifted = sum[WIDE_W-1:DROP_W];
        if (WIDE_W - DROP_W > ENTRY_W)
        begin
            if (shifted > (WIDE_W-DROP_W)'(64'sd2147483647))
                res = entry_t'(32'sh7fff_ffff);
            else if (shifted < (WIDE_W-DROP_W)'(-64'sd2147483648))
                res = entry_t'(32'sh8000_0000);
            else
                res = entry_t'(shifted);
        end
        else
        begin
            res = entry_t'(shifted);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/qspm_entry.sv
`default_nettype none

module qspm_entry
    import qspm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   en,
    input  wire rot_t   rot,
    input  wire scale_t scale,
    output entry_t      entry
);

    wide_t  prod_reg;
    wide_t  prod_next;
    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        prod_next  = wide_t'(rot) * wide_t'(scale);
        entry_next = round_sat(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

### rtl/quaternion_scale_position_to_matrix.sv
// quaternion, scale and position to 4x4 transform matrix, fixed point
//
// input stream s_*: one item holds quaternion x, y, z, w (q1.15), the
// scale of each axis (q8.8) and a translation (q16.16).
// output stream m_*: one item holds the nine rotation entries, each
// scaled by the scale of its column, and the translation, all q16.16.
// the constant entries 3, 7, 11 and 15 are not sent.
//
// four register stages: pairwise products, rotation terms, scale
// multiply, rounding into the output register. m_tvalid rises once an
// item reaches the output register; one item per cycle is taken for as
// long as the receiver keeps up.
// a stall of m_tready freezes all stages together; s_tready follows
// as soon as the output register holds an item that is not taken.
// reset clears the stage valid bits only; no item is left in flight.
`default_nettype none

module quaternion_scale_position_to_matrix
    import qspm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // entry_0, entry_1, entry_2, entry_4, entry_5, entry_6, entry_8, entry_9,
    // entry_10, entry_12, entry_13, entry_14
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic   en;
    logic   v1_reg, v2_reg, v3_reg, v4_reg;
    logic   v1_next;

    logic signed [QUAT_W-1:0] qx, qy, qz, qw;
    scale_t                   sc_in [AXES];
    logic [POS_W-1:0]         pos_in [AXES];

    prod_t  xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    rot_t   rot_reg  [ROT_N];
    rot_t   rot_next [ROT_N];
    scale_t sc1_reg [AXES];
    scale_t sc2_reg [AXES];
    logic [POS_W-1:0] pos1_reg [AXES];
    logic [POS_W-1:0] pos2_reg [AXES];
    logic [POS_W-1:0] pos3_reg [AXES];
    logic [POS_W-1:0] pos4_reg [AXES];
    entry_t entry_out [ROT_N];

    assign en       = !v4_reg || m_tready;
    assign s_tready = en;
    assign v1_next  = s_tvalid;

    assign qx = s_tdata[0*QUAT_W +: QUAT_W];
    assign qy = s_tdata[1*QUAT_W +: QUAT_W];
    assign qz = s_tdata[2*QUAT_W +: QUAT_W];
    assign qw = s_tdata[3*QUAT_W +: QUAT_W];

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            sc_in[a]  = s_tdata[4*QUAT_W + a*SCALE_W +: SCALE_W];
            pos_in[a] = s_tdata[4*QUAT_W + AXES*SCALE_W + a*POS_W +: POS_W];
        end
    end

    // rotation terms in output order, q2.30 with two bits of headroom
    always_comb
    begin
        rot_next[0] = ONE_Q30 - ((rot_t'(yy_reg) + rot_t'(zz_reg)) <<< 1);
        rot_next[1] = (rot_t'(xy_reg) - rot_t'(wz_reg)) <<< 1;
        rot_next[2] = (rot_t'(xz_reg) + rot_t'(wy_reg)) <<< 1;
        rot_next[3] = (rot_t'(xy_reg) + rot_t'(wz_reg)) <<< 1;
        rot_next[4] = ONE_Q30 - ((rot_t'(xx_reg) + rot_t'(zz_reg)) <<< 1);
        rot_next[5] = (rot_t'(yz_reg) - rot_t'(wx_reg)) <<< 1;
        rot_next[6] = (rot_t'(xz_reg) - rot_t'(wy_reg)) <<< 1;
        rot_next[7] = (rot_t'(yz_reg) + rot_t'(wx_reg)) <<< 1;
        rot_next[8] = ONE_Q30 - ((rot_t'(xx_reg) + rot_t'(yy_reg)) <<< 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= prod_t'(qx * qx);
            yy_reg <= prod_t'(qy * qy);
            zz_reg <= prod_t'(qz * qz);
            xy_reg <= prod_t'(qx * qy);
            xz_reg <= prod_t'(qx * qz);
            yz_reg <= prod_t'(qy * qz);
            wx_reg <= prod_t'(qw * qx);
            wy_reg <= prod_t'(qw * qy);
            wz_reg <= prod_t'(qw * qz);
            for (int i = 0; i < ROT_N; i++)
                rot_reg[i] <= rot_next[i];
            for (int a = 0; a < AXES; a++)
            begin
                sc1_reg[a]  <= sc_in[a];
                sc2_reg[a]  <= sc1_reg[a];
                pos1_reg[a] <= pos_in[a];
                pos2_reg[a] <= pos1_reg[a];
                pos3_reg[a] <= pos2_reg[a];
                pos4_reg[a] <= pos3_reg[a];
            end
        end
    end

    // entry i belongs to column i mod 3
    for (genvar i = 0; i < ROT_N; i++)
    begin : g_entry
        qspm_entry u_entry
        (
            .clk   (clk),
            .en    (en),
            .rot   (rot_reg[i]),
            .scale (sc2_reg[i % AXES]),
            .entry (entry_out[i])
        );
        assign m_tdata[i*ENTRY_W +: ENTRY_W] = entry_out[i];
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_pos
        assign m_tdata[(ROT_N + a)*ENTRY_W +: ENTRY_W] = pos4_reg[a];
    end

    assign m_tvalid = v4_reg;

endmodule

`default_nettype wire

### rtl/qspm_checker.sv
`default_nettype none

module qspm_checker
    import qspm_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [IN_DATA_W-1:0]  s_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int POS_IN_LO  = 4 * QUAT_W + AXES * SCALE_W;
    localparam int POS_OUT_LO = ROT_N * ENTRY_W;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output item changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // item taken with no stall since has passed pos1_reg to pos4_reg, its translation leaves now
    a_pos_latency: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && $past(s_tvalid && s_tready, 4)
        && $past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3)
        |-> m_tdata[POS_OUT_LO +: POS_W] == $past(s_tdata[POS_IN_LO +: POS_W], 4))
        else $error("translation does not match item taken four cycles earlier");

endmodule

bind quaternion_scale_position_to_matrix qspm_checker u_qspm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench
    import qspm_pkg::*;
();

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 16;
    localparam int PHASE_ITEMS = 450;
    localparam longint UNIT_Q30 = 64'sd1 <<< 30;
    localparam longint HALF_LSB = 64'sd1 <<< 21;
    localparam longint ENTRY_MAX = 64'sd2147483647;
    localparam longint ENTRY_MIN = -64'sd2147483648;

    // packed from the lowest bit up in the order of the input item
    typedef struct packed {
        logic signed [POS_W-1:0]   pos_z;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [SCALE_W-1:0] scale_z;
        logic signed [SCALE_W-1:0] scale_y;
        logic signed [SCALE_W-1:0] scale_x;
        logic signed [QUAT_W-1:0]  quat_w;
        logic signed [QUAT_W-1:0]  quat_z;
        logic signed [QUAT_W-1:0]  quat_y;
        logic signed [QUAT_W-1:0]  quat_x;
    } pose_t;

    // index 0 is entry_0, index 11 is entry_14
    typedef logic [ROT_N+AXES-1:0][ENTRY_W-1:0] matrix_t;

    class matrix_board;
        matrix_t pending_matrices[$];
        int      errors;
        int      inputs_noted;
        int      matrices_checked;
        string   entry_name [ROT_N+AXES] = '{"entry_0", "entry_1", "entry_2", "entry_4",
            "entry_5", "entry_6", "entry_8", "entry_9", "entry_10", "entry_12",
            "entry_13", "entry_14"};

        function new();
            errors           = 0;
            inputs_noted     = 0;
            matrices_checked = 0;
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        // rotation term in q2.30 times q8.8 scale, round half up into q16.16
        function entry_t scaled_term(input longint rot, input longint scl);
            longint prod;
            longint r;
            prod = rot * scl;
            r    = (prod + HALF_LSB) >>> DROP_W;
            if (r > ENTRY_MAX)
                r = ENTRY_MAX;
            if (r < ENTRY_MIN)
                r = ENTRY_MIN;
            return entry_t'(r);
        endfunction

        function matrix_t transform_of(input pose_t p);
            longint  x, y, z, w, sx, sy, sz;
            longint  xx, yy, zz, xy, xz, yz, wx, wy, wz;
            matrix_t m;
            x  = p.quat_x;
            y  = p.quat_y;
            z  = p.quat_z;
            w  = p.quat_w;
            sx = p.scale_x;
            sy = p.scale_y;
            sz = p.scale_z;
            xx = x * x;
            yy = y * y;
            zz = z * z;
            xy = x * y;
            xz = x * z;
            yz = y * z;
            wx = w * x;
            wy = w * y;
            wz = w * z;
            m[0]  = scaled_term(UNIT_Q30 - 2 * (yy + zz), sx);
            m[1]  = scaled_term(2 * (xy - wz), sy);
            m[2]  = scaled_term(2 * (xz + wy), sz);
            m[3]  = scaled_term(2 * (xy + wz), sx);
            m[4]  = scaled_term(UNIT_Q30 - 2 * (xx + zz), sy);
            m[5]  = scaled_term(2 * (yz - wx), sz);
            m[6]  = scaled_term(2 * (xz - wy), sx);
            m[7]  = scaled_term(2 * (yz + wx), sy);
            m[8]  = scaled_term(UNIT_Q30 - 2 * (xx + yy), sz);
            m[9]  = p.pos_x;
            m[10] = p.pos_y;
            m[11] = p.pos_z;
            return m;
        endfunction

        function void note_input(input pose_t p);
            pending_matrices.push_back(transform_of(p));
            inputs_noted++;
        endfunction

        task check_result(input matrix_t got);
            matrix_t want;
            if (pending_matrices.size() == 0)
            begin
                report($sformatf("matrix %h with none expected", got));
            end
            else
            begin
                want = pending_matrices.pop_front();
                matrices_checked++;
                for (int i = 0; i < ROT_N + AXES; i++)
                begin
                    if (got[i] !== want[i])
                        report($sformatf("matrix %0d %s: expected %h, got %h",
                            matrices_checked, entry_name[i], want[i], got[i]));
                end
            end
        endtask

        function int pending();
            return pending_matrices.size();
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int          send_idle_pct = 24;
    int          recv_idle_pct = 50;
    int          stall_cycles  = 0;
    matrix_board board;

    quaternion_scale_position_to_matrix dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(matrix_t'(m_tdata));
    end

    function automatic pose_t make_pose(input int qx, qy, qz, qw, sx, sy, sz,
                                        input logic [31:0] px, py, pz);
        pose_t p;
        p.quat_x  = QUAT_W'(qx);
        p.quat_y  = QUAT_W'(qy);
        p.quat_z  = QUAT_W'(qz);
        p.quat_w  = QUAT_W'(qw);
        p.scale_x = SCALE_W'(sx);
        p.scale_y = SCALE_W'(sy);
        p.scale_z = SCALE_W'(sz);
        p.pos_x   = px;
        p.pos_y   = py;
        p.pos_z   = pz;
        return p;
    endfunction

    // extremes and zero now and then, otherwise uniform
    function automatic logic [15:0] random_half();
        logic [15:0] v;
        case ($urandom_range(7))
            0:       v = 16'h8000;
            1:       v = 16'h7fff;
            2:       v = 16'h0000;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] v;
        case ($urandom_range(7))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic pose_t random_pose();
        pose_t p;
        p.quat_x  = random_half();
        p.quat_y  = random_half();
        p.quat_z  = random_half();
        p.quat_w  = random_half();
        p.scale_x = random_half();
        p.scale_y = random_half();
        p.scale_z = random_half();
        p.pos_x   = random_word();
        p.pos_y   = random_word();
        p.pos_z   = random_word();
        return p;
    endfunction

    task automatic send_pose(input pose_t p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_input(p);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_pose(random_pose());
    endtask

    initial
    begin : watchdog
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("no item moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        board = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero, identity and its negative, single axis half turns
        send_pose(make_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pose(make_pose(0, 0, 0, 32767, 256, 256, 256, 0, 0, 0));
        send_pose(make_pose(0, 0, 0, -32768, 256, 256, 256, 32'h0001_0000,
            32'hffff_0000, 32'h0000_8000));
        send_pose(make_pose(32767, 0, 0, 0, 256, 256, 256, 0, 0, 0));
        send_pose(make_pose(0, -32768, 0, 0, 256, 256, 256, 0, 0, 0));
        send_pose(make_pose(0, 0, 32767, 0, 256, 256, 256, 0, 0, 0));
        // largest magnitudes everywhere
        send_pose(make_pose(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_pose(make_pose(32767, 32767, 32767, 32767, 32767, 32767, 32767,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_pose(make_pose(-32768, -32768, -32768, -32768, 32767, 32767, 32767,
            32'h7fff_ffff, 32'h8000_0000, 32'h0));
        send_pose(make_pose(32767, -32768, 32767, -32768, -32768, 32767, -32768,
            32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
        // unit quaternion with mirrored and uneven scales
        send_pose(make_pose(16384, 16384, 16384, 16384, -256, 512, -128,
            32'h0003_8000, 32'hfffc_8000, 32'h0));
        send_pose(make_pose(16384, -16384, 16384, -16384, 256, -256, 256, 0, 0, 0));
        // not unit length
        send_pose(make_pose(32767, 32767, 32767, 32767, -256, -256, -256, 0, 0, 0));
        send_pose(make_pose(100, -200, 300, 400, 256, 256, 256, 0, 0, 0));
        // smallest scale, rounding of tiny terms
        send_pose(make_pose(1, 1, -1, 1, 1, 1, 1, 32'h1, 32'h1, 32'h1));
        send_pose(make_pose(-1, -1, -1, -1, -1, -1, -1, 32'hffff_ffff,
            32'hffff_ffff, 32'hffff_ffff));
        send_pose(make_pose(0, 0, 0, 0, 1, -1, 1, 0, 0, 0));
        // alternating bit patterns, then a quarter turn about x with uneven scales
        send_pose(make_pose(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
            16'haaaa, 16'h5555, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));
        send_pose(make_pose(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
            16'h5555, 16'haaaa, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa));
        send_pose(make_pose(23170, 0, 0, 23170, 384, 256, 128,
            32'h0010_0000, 32'h0, 32'hfff0_0000));

        send_random(PHASE_ITEMS);
        send_idle_pct = 50;
        recv_idle_pct = 24;
        send_random(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(PHASE_ITEMS);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d transforms sent, %0d matrices checked, %0d mismatches",
            board.inputs_noted, board.matrices_checked, board.errors);
        $display("idling on either side, then neither; extreme and random fields");
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
